FILE: hdl/isrch_pkg.sv
// shared constants for the interpolation search block
`default_nettype none
package isrch_pkg;
  localparam int IDX_W = 6;
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/isrch_tbl.sv
// table memory: one write port, one registered read port
`default_nettype none
module isrch_tbl #(
  parameter int TABLE_DEPTH = isrch_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = isrch_pkg::DEF_VALUE_WIDTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [VALUE_WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [VALUE_WIDTH-1:0] rdata
);
  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/isrch_div.sv
// bit-serial unit for floor(diff * n / span), one half step per cycle
`default_nettype none
module isrch_div #(
  parameter int VALUE_WIDTH = isrch_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [VALUE_WIDTH-1:0]        diff,
  input  wire logic [isrch_pkg::IDX_W-1:0]   n,
  input  wire logic [VALUE_WIDTH-1:0]        span,
  output logic                               done,
  output logic      [isrch_pkg::IDX_W-1:0]   q
);
  localparam int NW = isrch_pkg::IDX_W;
  localparam int CW = $clog2(NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              phase_r, phase_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     q_r, q_nxt;
  logic [VALUE_WIDTH-1:0] r_r, r_nxt;
  logic [VALUE_WIDTH-1:0] span_r, span_nxt;
  logic [VALUE_WIDTH-1:0] diff_r, diff_nxt;
  logic [VALUE_WIDTH-1:0] sd_r, sd_nxt;
  logic [VALUE_WIDTH:0]   dbl;
  logic                   ge_dbl;
  logic                   ge_add;

  always_comb begin
    dbl = {r_r, 1'b0};
    ge_dbl = dbl >= {1'b0, span_r};
    ge_add = r_r >= sd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    n_nxt = n_r;
    q_nxt = q_r;
    r_nxt = r_r;
    span_nxt = span_r;
    diff_nxt = diff_r;
    sd_nxt = sd_r;
    if (start) begin
      busy_nxt = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt = CW'(NW - 1);
      n_nxt = n;
      q_nxt = '0;
      r_nxt = '0;
      span_nxt = span;
      diff_nxt = diff;
      sd_nxt = span - diff;
    end else if (busy_r) begin
      if (!phase_r) begin
        // double the multiplier prefix
        q_nxt = {q_r[NW-2:0], 1'b0} + NW'(ge_dbl);
        r_nxt = ge_dbl ? VALUE_WIDTH'(dbl - {1'b0, span_r}) : VALUE_WIDTH'(dbl);
        phase_nxt = 1'b1;
      end else begin
        if (n_r[NW-1]) begin
          q_nxt = q_r + NW'(ge_add);
          r_nxt = ge_add ? r_r - sd_r : r_r + diff_r;
        end
        n_nxt = {n_r[NW-2:0], 1'b0};
        phase_nxt = 1'b0;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      phase_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    span_r <= span_nxt;
    diff_r <= diff_nxt;
    sd_r <= sd_nxt;
  end

  assign done = done_r;
  assign q = q_r;
endmodule
`default_nettype wire

FILE: hdl/interpolation_search.sv
// interpolation search top level: control sequencer around the table and divider
// a write transaction is taken in idle; each search probe runs two end reads,
// the end check, the serial divider and the probe compare; an end check
// that stops the search goes straight to the finish state, an empty range runs
// no probe, the result enters the output register once free; probes depend on the data
// one item in work at a time; reset clears sequencer and output valid, not the table
`default_nettype none
module interpolation_search #(
  parameter int TABLE_DEPTH = isrch_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = isrch_pkg::DEF_VALUE_WIDTH,
  localparam int IN_TDATA_W = ((3 * isrch_pkg::IDX_W + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((isrch_pkg::IDX_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // entry_index, value, range_low, range_high
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic [0:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // position
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic      [0:0]             out_tuser
);
  localparam int IW = isrch_pkg::IDX_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RLO  = 3'd1;
  localparam logic [2:0] S_RHI  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PRB  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [IW-1:0]          lo_r, lo_nxt;
  logic [IW-1:0]          hi_r, hi_nxt;
  logic [IW-1:0]          pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] vlo_r, vlo_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [IW-1:0]          res_pos_r, res_pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [IW-1:0]          out_pos_r, out_pos_nxt;

  logic                   in_cmd;
  logic [IW-1:0]          in_idx;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [IW-1:0]          in_rlo;
  logic [IW-1:0]          in_rhi;
  logic [IW-1:0]          rhi_clamped;
  logic                   in_fire;

  logic                   tbl_we;
  logic [AW-1:0]          tbl_waddr;
  logic [AW-1:0]          tbl_raddr;
  logic [VALUE_WIDTH-1:0] tbl_rdata;
  logic [VALUE_WIDTH-1:0] rb;
  logic [IW-1:0]          raddr_idx;
  logic [IW-1:0]          probe_pos;

  logic                   div_start;
  logic                   div_done;
  logic [IW-1:0]          div_q;
  logic [VALUE_WIDTH-1:0] div_diff;
  logic [VALUE_WIDTH-1:0] div_span;
  logic [IW-1:0]          div_n;

  assign in_cmd   = in_tuser[0];
  assign in_idx   = in_tdata[IW-1:0];
  assign in_value = in_tdata[IW +: VALUE_WIDTH];
  assign in_rlo   = in_tdata[IW + VALUE_WIDTH +: IW];
  assign in_rhi   = in_tdata[2 * IW + VALUE_WIDTH +: IW];
  assign rhi_clamped = (int'(in_rhi) > TABLE_DEPTH - 1) ? IW'(TABLE_DEPTH - 1) : in_rhi;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;

  assign tbl_we = in_fire && (in_cmd == isrch_pkg::CMD_WRITE) && (int'(in_idx) < TABLE_DEPTH);
  assign tbl_waddr = AW'(in_idx);
  assign rb = tbl_rdata ^ SIGN;

  assign probe_pos = lo_r + div_q;
  assign div_diff = key_r - vlo_r;
  assign div_span = rb - vlo_r;
  assign div_n = hi_r - lo_r;

  always_comb begin
    case (state_r)
      S_RLO:   raddr_idx = lo_r;
      S_RHI:   raddr_idx = hi_r;
      S_DIV:   raddr_idx = probe_pos;
      default: raddr_idx = lo_r;
    endcase
  end
  assign tbl_raddr = AW'(raddr_idx);

  always_comb begin
    state_nxt = state_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    pos_nxt = pos_r;
    key_nxt = key_r;
    vlo_nxt = vlo_r;
    res_found_nxt = res_found_r;
    res_pos_nxt = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt = out_pos_r;
    div_start = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_cmd == isrch_pkg::CMD_SEARCH)) begin
          lo_nxt = in_rlo;
          hi_nxt = rhi_clamped;
          key_nxt = in_value ^ SIGN;
          res_found_nxt = 1'b0;
          res_pos_nxt = '0;
          state_nxt = (in_rlo > rhi_clamped) ? S_FIN : S_RLO;
        end
      end
      S_RLO: begin
        state_nxt = S_RHI;
      end
      S_RHI: begin
        vlo_nxt = rb;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (key_r < vlo_r || key_r > rb) begin
          state_nxt = S_FIN;
        end else if (rb == vlo_r) begin
          // flat range, single compare
          res_found_nxt = (key_r == vlo_r);
          res_pos_nxt = (key_r == vlo_r) ? lo_r : '0;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          pos_nxt = probe_pos;
          state_nxt = S_PRB;
        end
      end
      S_PRB: begin
        if (key_r == rb) begin
          res_found_nxt = 1'b1;
          res_pos_nxt = pos_r;
          state_nxt = S_FIN;
        end else if (key_r < rb) begin
          if (pos_r == lo_r) begin
            state_nxt = S_FIN;
          end else begin
            hi_nxt = pos_r - 1'b1;
            state_nxt = S_RLO;
          end
        end else begin
          if (pos_r == hi_r) begin
            state_nxt = S_FIN;
          end else begin
            lo_nxt = pos_r + 1'b1;
            state_nxt = S_RLO;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt = res_pos_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    vlo_r <= vlo_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r <= out_pos_nxt;
  end

  isrch_tbl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(in_value),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  isrch_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .diff (div_diff),
    .n    (div_n),
    .span (div_span),
    .done (div_done),
    .q    (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = OUT_TDATA_W'(out_pos_r);
  assign out_tuser = out_found_r;

  // a probe never leaves the current range
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> (div_q <= div_n))
    else $error("probe offset beyond range");

  // the range stays non-empty while reads are issued
  a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RLO) |-> (lo_r <= hi_r && int'(hi_r) < TABLE_DEPTH))
    else $error("empty or out of bounds range in search");

  // an accepted search always leaves idle
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == isrch_pkg::CMD_SEARCH) |=> (state_r != S_IDLE))
    else $error("search transaction dropped");
endmodule
`default_nettype wire
